// ----- sv/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int MAX_REGIONS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_BOUNDS  = 2'd3
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] heap_base;
    logic signed [31:0] heap_limit;
    logic signed [31:0] request_size;
    logic signed [31:0] free_address;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] block_address;
    status_t            status;
  } out_data_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } region_entry_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_WALK_RD,
    CS_WALK_EV,
    CS_TAIL,
    CS_PLACE,
    CS_INS_RD,
    CS_INS_EV,
    CS_INS_NEW,
    CS_FREE_RD,
    CS_FREE_EV,
    CS_SHIFT_RD,
    CS_SHIFT_EV,
    CS_DONE
  } ctrl_state_t;

endpackage

// ----- sv/ffba_region_ram.sv -----
// Region table RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module ffba_region_ram #(
  parameter int DEPTH  = ffba_pkg::MAX_REGIONS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  ffba_pkg::region_entry_t wdata,
  input  logic [ADDR_W-1:0]       raddr,
  output ffba_pkg::region_entry_t rdata
);

  ffba_pkg::region_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ffba_out_reg.sv -----
// Output register holding one finished result for the out channel.
`timescale 1ns / 1ps

module ffba_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  ffba_pkg::out_data_t res_data,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_data_t out_data
);

  logic                valid_r;
  ffba_pkg::out_data_t data_r;

  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      valid_r <= 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res_data;
    end
  end

endmodule

// ----- sv/ffba_ctrl.sv -----
// Request sequencer: walks, inserts and removes table entries through the RAM.
`timescale 1ns / 1ps

module ffba_ctrl #(
  parameter int MAX_REGIONS = ffba_pkg::MAX_REGIONS_DEF,
  parameter int IDX_W       = $clog2(MAX_REGIONS),
  parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ffba_pkg::in_data_t      in_data,
  output logic                    mem_we,
  output logic [IDX_W-1:0]        mem_waddr,
  output ffba_pkg::region_entry_t mem_wdata,
  output logic [IDX_W-1:0]        mem_raddr,
  input  ffba_pkg::region_entry_t mem_rdata,
  output logic                    res_valid,
  output ffba_pkg::out_data_t     res_data,
  input  logic                    res_ready
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  ffba_pkg::ctrl_state_t state_r, state_nxt;
  ffba_pkg::in_data_t    req_r, req_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic signed [33:0]    cursor_r, cursor_nxt;
  logic signed [31:0]    res_addr_r, res_addr_nxt;
  ffba_pkg::status_t     res_status_r, res_status_nxt;

  logic                  bad_bounds;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      idx_dec;
  logic signed [34:0]    rd_start35;
  logic signed [34:0]    rd_size35;
  logic signed [34:0]    size35;
  logic signed [34:0]    cursor35;
  logic signed [34:0]    gap;
  logic signed [34:0]    tail_end;
  logic signed [34:0]    region_end;
  logic                  cursor_in_range;
  ffba_pkg::region_entry_t new_entry;

  assign bad_bounds = (in_data.heap_base <= 0) || (in_data.heap_limit <= 0);
  assign idx_inc    = idx_r + CNT_ONE;
  assign idx_dec    = idx_r - CNT_ONE;

  assign rd_start35 = 35'(signed'(mem_rdata.start));
  assign rd_size35  = 35'(signed'(mem_rdata.size));
  assign size35     = 35'(req_r.request_size);
  assign cursor35   = 35'(cursor_r);
  assign gap        = rd_start35 - cursor35;
  assign tail_end   = cursor35 + size35;
  assign region_end = rd_start35 + rd_size35;

  // upper bits must all match the 32-bit sign bit
  assign cursor_in_range = (cursor_r[33:31] == 3'b000) || (cursor_r[33:31] == 3'b111);

  assign new_entry.start = cursor_r[31:0];
  assign new_entry.size  = req_r.request_size;

  assign res_data.block_address = res_addr_r;
  assign res_data.status        = res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::CS_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    cursor_r     <= cursor_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[IDX_W-1:0];
    mem_wdata      = mem_rdata;
    mem_raddr      = idx_r[IDX_W-1:0];

    case (state_r)
      ffba_pkg::CS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt      = in_data;
          idx_nxt      = '0;
          cursor_nxt   = 34'(in_data.heap_base);
          res_addr_nxt = '0;
          if (bad_bounds) begin
            res_status_nxt = ffba_pkg::ST_BOUNDS;
            state_nxt      = ffba_pkg::CS_DONE;
          end else if (in_data.mode == ffba_pkg::MODE_FREE) begin
            if (count_r == '0) begin
              res_status_nxt = ffba_pkg::ST_NOSPACE;
              state_nxt      = ffba_pkg::CS_DONE;
            end else begin
              state_nxt = ffba_pkg::CS_FREE_RD;
            end
          end else if (count_r == '0) begin
            state_nxt = ffba_pkg::CS_TAIL;
          end else begin
            state_nxt = ffba_pkg::CS_WALK_RD;
          end
        end
      end

      ffba_pkg::CS_WALK_RD: begin
        state_nxt = ffba_pkg::CS_WALK_EV;
      end

      ffba_pkg::CS_WALK_EV: begin
        if (gap >= size35) begin
          state_nxt = ffba_pkg::CS_PLACE;
        end else begin
          cursor_nxt = region_end[33:0];
          idx_nxt    = idx_inc;
          state_nxt  = (idx_inc == count_r) ? ffba_pkg::CS_TAIL : ffba_pkg::CS_WALK_RD;
        end
      end

      ffba_pkg::CS_TAIL: begin
        if (tail_end < 35'(req_r.heap_limit)) begin
          state_nxt = ffba_pkg::CS_PLACE;
        end else begin
          res_status_nxt = ffba_pkg::ST_NOSPACE;
          state_nxt      = ffba_pkg::CS_DONE;
        end
      end

      ffba_pkg::CS_PLACE: begin
        idx_nxt = count_r;
        if (!cursor_in_range) begin
          res_status_nxt = ffba_pkg::ST_NOSPACE;
          state_nxt      = ffba_pkg::CS_DONE;
        end else if (count_r >= CNT_MAX) begin
          res_status_nxt = ffba_pkg::ST_FULL;
          state_nxt      = ffba_pkg::CS_DONE;
        end else if (count_r == '0) begin
          state_nxt = ffba_pkg::CS_INS_NEW;
        end else begin
          state_nxt = ffba_pkg::CS_INS_RD;
        end
      end

      // back-to-front shift: entries above the new start move up one slot
      ffba_pkg::CS_INS_RD: begin
        mem_raddr = idx_dec[IDX_W-1:0];
        state_nxt = ffba_pkg::CS_INS_EV;
      end

      ffba_pkg::CS_INS_EV: begin
        mem_we = 1'b1;
        if (signed'(mem_rdata.start) > signed'(cursor_r[31:0])) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec == '0) ? ffba_pkg::CS_INS_NEW : ffba_pkg::CS_INS_RD;
        end else begin
          mem_wdata      = new_entry;
          count_nxt      = count_r + CNT_ONE;
          res_addr_nxt   = cursor_r[31:0];
          res_status_nxt = ffba_pkg::ST_OK;
          state_nxt      = ffba_pkg::CS_DONE;
        end
      end

      ffba_pkg::CS_INS_NEW: begin
        mem_we         = 1'b1;
        mem_wdata      = new_entry;
        count_nxt      = count_r + CNT_ONE;
        res_addr_nxt   = cursor_r[31:0];
        res_status_nxt = ffba_pkg::ST_OK;
        state_nxt      = ffba_pkg::CS_DONE;
      end

      ffba_pkg::CS_FREE_RD: begin
        state_nxt = ffba_pkg::CS_FREE_EV;
      end

      ffba_pkg::CS_FREE_EV: begin
        idx_nxt = idx_inc;
        if (signed'(mem_rdata.start) == req_r.free_address) begin
          if (idx_inc == count_r) begin
            count_nxt      = count_r - CNT_ONE;
            res_status_nxt = ffba_pkg::ST_OK;
            state_nxt      = ffba_pkg::CS_DONE;
          end else begin
            state_nxt = ffba_pkg::CS_SHIFT_RD;
          end
        end else if (idx_inc == count_r) begin
          res_status_nxt = ffba_pkg::ST_NOSPACE;
          state_nxt      = ffba_pkg::CS_DONE;
        end else begin
          state_nxt = ffba_pkg::CS_FREE_RD;
        end
      end

      // front-to-back shift closing the hole left by the freed entry
      ffba_pkg::CS_SHIFT_RD: begin
        state_nxt = ffba_pkg::CS_SHIFT_EV;
      end

      ffba_pkg::CS_SHIFT_EV: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec[IDX_W-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_inc;
        if (idx_inc == count_r) begin
          count_nxt      = count_r - CNT_ONE;
          res_status_nxt = ffba_pkg::ST_OK;
          state_nxt      = ffba_pkg::CS_DONE;
        end else begin
          state_nxt = ffba_pkg::CS_SHIFT_RD;
        end
      end

      ffba_pkg::CS_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ffba_pkg::CS_IDLE;
        end
      end

      default: begin
        state_nxt = ffba_pkg::CS_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("region count above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::CS_IDLE || state_r == ffba_pkg::CS_DONE) |-> !mem_we)
    else $error("table write outside a request");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_ONE || count_r + CNT_ONE == $past(count_r)))
    else $error("region count moved by more than one");

  a_count_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (state_r == ffba_pkg::CS_DONE))
    else $error("region count changed without finishing a request");
`endif

endmodule

// ----- sv/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator.
`timescale 1ns / 1ps

// First-fit block allocator. The block keeps up to MAX_REGIONS allocated
// regions as (start, size) pairs sorted by start, in a single RAM with one
// write port and a registered read port. An allocate request (mode 0) walks
// the table from heap_base and takes the first gap in front of a region that
// holds request_size; failing that it takes the tail if cursor + size stays
// strictly below heap_limit, then inserts the new region in order. A free
// request (mode 1) removes the first region whose start equals free_address.
// Status: 0 ok, 1 no space / address not found, 2 table full, 3 bad bounds
// (heap_base or heap_limit not positive); block_address is 0 unless an
// allocate succeeds. All address math is done wide, so nothing wraps.
// Flow: one request is in work at a time. Each table entry visited takes a
// RAM read state and then an evaluate state, because every step depends on
// the read data of the previous one. An allocate walks entries from the
// front, falls through to the tail check when no gap fits, and on insert
// shifts the entries above the new start up by one slot; a free searches
// entries from the front and shifts the ones behind the match down. The
// next request is taken as soon as the current result is in the output
// register, even while that result still waits on out_stall. No clearing
// pass is needed after reset: only entries below the region count are ever
// read.

module first_fit_block_allocator_unit #(
  parameter int MAX_REGIONS = ffba_pkg::MAX_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_data_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_data_t out_data
);

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // table RAM port
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  ffba_pkg::region_entry_t mem_wdata;
  ffba_pkg::region_entry_t mem_rdata;

  // finished result toward the output register
  logic                    res_valid;
  logic                    res_ready;
  ffba_pkg::out_data_t     res_data;

  ffba_region_ram #(
    .DEPTH  (MAX_REGIONS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer owns the region count and all table walks
  ffba_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // result slot decouples the sequencer from out_stall
  ffba_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
